### rtl/core/lru_key_value_cache_top_defines.svh
// Assertion macros shared by the cache RTL.
`ifndef LRU_KEY_VALUE_CACHE_TOP_DEFINES_SVH
`define LRU_KEY_VALUE_CACHE_TOP_DEFINES_SVH
`ifndef SYNTHESIS
`define LKVC_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("lkvc assertion failed");
`define LKVC_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("lkvc assertion failed");
`else
`define LKVC_ASSERT_NOW(label, ante, cons)
`define LKVC_ASSERT_NEXT(label, ante, cons)
`endif
`endif

### rtl/core/lkvc_pkg.sv
`default_nettype none
package lkvc_pkg;
  localparam int KEY_W  = 16;
  localparam int DATA_W = 32;
  localparam int CAP_W  = 5;
  localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;

  localparam logic OP_GET = 1'b0;
  localparam logic OP_PUT = 1'b1;

  typedef struct packed {
    logic cmp_en;
    logic clear;
    logic upd;
  } cell_ctrl_t;
endpackage
`default_nettype wire

### rtl/core/lkvc_req_if.sv
`default_nettype none
interface lkvc_req_if;
  logic                                 valid;
  logic                                 ready;
  logic                                 opcode;
  logic [lkvc_pkg::KEY_W-1:0]           key;
  logic signed [lkvc_pkg::DATA_W-1:0]   data_in;
  modport source (output valid, opcode, key, data_in, input ready);
  modport sink (input valid, opcode, key, data_in, output ready);
endinterface
`default_nettype wire

### rtl/core/lkvc_rsp_if.sv
`default_nettype none
interface lkvc_rsp_if;
  logic                                 valid;
  logic                                 ready;
  logic                                 hit;
  logic signed [lkvc_pkg::DATA_W-1:0]   data_out;
  modport source (output valid, hit, data_out, input ready);
  modport sink (input valid, hit, data_out, output ready);
endinterface
`default_nettype wire

### rtl/core/lkvc_cfg_if.sv
`default_nettype none
interface lkvc_cfg_if;
  logic                         valid;
  logic                         ready;
  logic [lkvc_pkg::CAP_W-1:0]   capacity;
  modport source (output valid, capacity, input ready);
  modport sink (input valid, capacity, output ready);
endinterface
`default_nettype wire

### rtl/core/lru_key_value_cache_top.sv
// Channel  Dir  Word
// req_i    in   opcode, key, data_in
// rsp_o    out  hit, data_out
// cfg_i    in   capacity
//
// An accepted item first latches a key compare in every cell of the chain; the update
// step then shifts entries back to put a hit or put entry at the front and loads the result register.
// A result waiting in the output register holds the update step, so no new item is taken.
// Reset leaves the cache empty with capacity 16; the configuration channel is always ready
// and a write empties the cache.
`default_nettype none
`include "lru_key_value_cache_top_defines.svh"
module lru_key_value_cache_top #(
  parameter int ENTRIES    = 16,
  parameter int KEY_BITS   = 16,
  parameter int VALUE_BITS = 32
) (
  input  wire      clk_i,
  input  wire      rst_ni,
  lkvc_req_if.sink   req_i,
  lkvc_rsp_if.source rsp_o,
  lkvc_cfg_if.sink   cfg_i
);

  localparam int KeyW = (KEY_BITS < lkvc_pkg::KEY_W) ? KEY_BITS : lkvc_pkg::KEY_W;
  localparam int CntW = $clog2(ENTRIES + 1);

  localparam logic StIdle = 1'b0;
  localparam logic StUpd  = 1'b1;

  logic                       state_q, state_d;
  logic                       op_q;
  logic [KeyW-1:0]            key_q;
  logic [VALUE_BITS-1:0]      data_q;
  logic [lkvc_pkg::CAP_W-1:0] cap_q;
  logic                       out_valid_q;
  logic                       hit_q;
  logic [lkvc_pkg::DATA_W-1:0] data_out_q;

  logic                       accept;
  logic                       upd_go;
  logic [CntW-1:0]            eff_cap;
  lkvc_pkg::cell_ctrl_t       ctrl;

  logic [ENTRIES-1:0]         valid_vec;
  logic [ENTRIES-1:0]         match_vec;
  logic [ENTRIES-1:0]         shift_vec;
  logic [KeyW-1:0]            key_arr [ENTRIES];
  logic [VALUE_BITS-1:0]      val_arr [ENTRIES];
  logic [VALUE_BITS-1:0]      hit_val;
  logic [VALUE_BITS-1:0]      front_val;
  logic                       hit_any;

  assign req_i.ready = (state_q == StIdle);
  assign cfg_i.ready = 1'b1;
  assign accept      = req_i.valid && req_i.ready;
  assign upd_go      = (state_q == StUpd) && (!out_valid_q || rsp_o.ready);

  assign ctrl.cmp_en = accept;
  assign ctrl.clear  = cfg_i.valid;
  assign ctrl.upd    = upd_go;

  always_comb begin
    if (cap_q == '0) begin
      eff_cap = CntW'(1);
    end else if (int'(cap_q) > ENTRIES) begin
      eff_cap = CntW'(ENTRIES);
    end else begin
      eff_cap = CntW'(cap_q);
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      StIdle: begin
        if (accept) begin
          state_d = StUpd;
        end
      end
      StUpd: begin
        if (upd_go) begin
          state_d = StIdle;
        end
      end
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      cap_q       <= lkvc_pkg::CAP_RESET;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cfg_i.valid) begin
        cap_q <= cfg_i.capacity;
      end
      if (upd_go) begin
        out_valid_q <= 1'b1;
      end else if (rsp_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      op_q   <= req_i.opcode;
      key_q  <= req_i.key[KeyW-1:0];
      data_q <= VALUE_BITS'(req_i.data_in);
    end
    if (upd_go) begin
      hit_q <= hit_any;
      if (op_q == lkvc_pkg::OP_PUT) begin
        data_out_q <= '0;
      end else if (hit_any) begin
        data_out_q <= lkvc_pkg::DATA_W'($signed(hit_val));
      end else begin
        data_out_q <= '1;
      end
    end
  end

  assign rsp_o.valid    = out_valid_q;
  assign rsp_o.hit      = hit_q;
  assign rsp_o.data_out = data_out_q;

  always_comb begin
    hit_val = '0;
    for (int i = 0; i < ENTRIES; i++) begin
      hit_val = hit_val | ({VALUE_BITS{match_vec[i]}} & val_arr[i]);
    end
  end

  assign hit_any   = |match_vec;
  assign front_val = (op_q == lkvc_pkg::OP_PUT) ? data_q : hit_val;

  // A hit moves every entry in front of the matching cell back by one; a put of a new
  // key moves the whole list back, dropping the oldest entry at the capacity edge.
  always_comb begin
    for (int i = 0; i < ENTRIES; i++) begin
      if (hit_any) begin
        shift_vec[i] = |(match_vec >> i);
      end else if (op_q == lkvc_pkg::OP_PUT) begin
        shift_vec[i] = CntW'(i) < eff_cap;
      end else begin
        shift_vec[i] = 1'b0;
      end
    end
  end

  for (genvar g = 0; g < ENTRIES; g++) begin : g_cell
    logic                  prev_valid;
    logic [KeyW-1:0]       prev_key;
    logic [VALUE_BITS-1:0] prev_value;

    if (g == 0) begin : g_front
      assign prev_valid = 1'b1;
      assign prev_key   = key_q;
      assign prev_value = front_val;
    end else begin : g_link
      assign prev_valid = valid_vec[g-1];
      assign prev_key   = key_arr[g-1];
      assign prev_value = val_arr[g-1];
    end

    lkvc_cell #(
      .KEY_W (KeyW),
      .VAL_W (VALUE_BITS)
    ) u_cell (
      .clk_i        (clk_i),
      .rst_ni       (rst_ni),
      .ctrl_i       (ctrl),
      .shift_i      (shift_vec[g]),
      .cmp_key_i    (req_i.key[KeyW-1:0]),
      .prev_valid_i (prev_valid),
      .prev_key_i   (prev_key),
      .prev_value_i (prev_value),
      .valid_o      (valid_vec[g]),
      .key_o        (key_arr[g]),
      .value_o      (val_arr[g]),
      .match_o      (match_vec[g])
    );
  end

  // Valid entries always fill the front of the chain without gaps.
  `LKVC_ASSERT_NOW(a_valid_packed, 1'b1, (ENTRIES'(valid_vec + 1'b1) & valid_vec) == '0)
  `LKVC_ASSERT_NOW(a_match_unique, 1'b1, $onehot0(match_vec))
  `LKVC_ASSERT_NOW(a_within_cap, 1'b1, $countones(valid_vec) <= int'(eff_cap))
  `LKVC_ASSERT_NEXT(a_accept_busy, accept, !req_i.ready)

endmodule
`default_nettype wire

### rtl/core/lkvc_cell.sv
`default_nettype none
module lkvc_cell #(
  parameter int KEY_W = 16,
  parameter int VAL_W = 32
) (
  input  wire                  clk_i,
  input  wire                  rst_ni,
  input  lkvc_pkg::cell_ctrl_t ctrl_i,
  input  wire                  shift_i,
  input  wire [KEY_W-1:0]      cmp_key_i,
  input  wire                  prev_valid_i,
  input  wire [KEY_W-1:0]      prev_key_i,
  input  wire [VAL_W-1:0]      prev_value_i,
  output logic                 valid_o,
  output logic [KEY_W-1:0]     key_o,
  output logic [VAL_W-1:0]     value_o,
  output logic                 match_o
);

  logic             valid_q;
  logic             match_q;
  logic [KEY_W-1:0] key_q;
  logic [VAL_W-1:0] value_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      match_q <= 1'b0;
    end else begin
      if (ctrl_i.clear) begin
        valid_q <= 1'b0;
      end else if (ctrl_i.upd && shift_i) begin
        valid_q <= prev_valid_i;
      end
      if (ctrl_i.cmp_en) begin
        match_q <= valid_q && (key_q == cmp_key_i);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.upd && shift_i) begin
      key_q   <= prev_key_i;
      value_q <= prev_value_i;
    end
  end

  assign valid_o = valid_q;
  assign key_o   = key_q;
  assign value_o = value_q;
  assign match_o = match_q;

endmodule
`default_nettype wire
